### hw/rtl/pibl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program image block loader package
// Shared types, codes and helpers for the loader front end, queue and parser.
// ----------------------------------------------------------------------------
package pibl_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrWidth  = 4;

  typedef enum logic [3:0] {
    PH_ID,
    PH_COUNT,
    PH_SEP1,
    PH_SEP2,
    PH_NUMBER,
    PH_BLKID,
    PH_ADDR,
    PH_LENGTH,
    PH_SEP3,
    PH_DATA,
    PH_DONE,
    PH_ERR_ID,
    PH_ERR_SEP,
    PH_ERR_SEQ
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_DATA,
    ST_DONE,
    ST_BAD_ID,
    ST_BAD_SEP,
    ST_BAD_SEQ,
    ST_IGNORED
  } status_t;

  typedef enum logic [1:0] {
    REG_IMAGE_ID,
    REG_SEPARATOR,
    REG_SWAP
  } reg_index_t;

  // One classified image word as it travels from the front end to the parser.
  typedef struct packed {
    logic [31:0] word;
    logic        restart;
    logic        id_match;
    logic        sep_match;
  } item_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

### hw/rtl/pibl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loader front end
// Accepts image words, applies the byte order and compares each word against
// the identifier and separator values before it enters the queue.
// ----------------------------------------------------------------------------
module pibl_front
  import pibl_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic        restart,
  input  logic [31:0] image_identifier,
  input  logic [31:0] separator_value,
  input  logic        swap_bytes,
  input  logic        queue_ready,
  output logic        push,
  output item_t       push_item
);

  logic [31:0] word;

  assign word     = swap_bytes ? swap32(data_word) : data_word;
  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  always_comb begin
    push_item.word      = word;
    push_item.restart   = restart;
    push_item.id_match  = (word == image_identifier);
    push_item.sep_match = (word == separator_value);
  end

endmodule

### hw/rtl/pibl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loader word queue
// Small FIFO of classified words between the front end and the parser.
// ----------------------------------------------------------------------------
module pibl_queue
  import pibl_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  item_t                 entries [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;

  assign ready     = (count != FullCount);
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != FullCount))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

### hw/rtl/pibl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loader parser
// Walks the image layout one queued word per cycle while results are taken,
// keeps the block counters and registers one result per word for output.
// ----------------------------------------------------------------------------
module pibl_back
  import pibl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [31:0] write_address,
  output logic [31:0] write_data,
  output logic [2:0]  status
);

  phase_t      phase, phase_next;
  logic [31:0] blocks_total, blocks_total_next;
  logic [31:0] block_index, block_index_next;
  logic [31:0] next_address, next_address_next;
  logic [31:0] words_left, words_left_next;

  phase_t      ph;
  logic [31:0] bt, bi, na, wl;
  logic [31:0] bi_inc, wl_dec;
  logic        last_block;
  logic        we;
  logic [31:0] addr, data;
  status_t     st;

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID;
      blocks_total <= '0;
      block_index  <= '0;
      next_address <= '0;
      words_left   <= '0;
    end else if (pop) begin
      phase        <= phase_next;
      blocks_total <= blocks_total_next;
      block_index  <= block_index_next;
      next_address <= next_address_next;
      words_left   <= words_left_next;
    end
  end

  always_comb begin
    // A restart word sees the reset state and is then taken as the identifier.
    ph = q_item.restart ? PH_ID : phase;
    bt = q_item.restart ? '0 : blocks_total;
    bi = q_item.restart ? '0 : block_index;
    na = q_item.restart ? '0 : next_address;
    wl = q_item.restart ? '0 : words_left;

    bi_inc     = bi + 32'd1;
    wl_dec     = wl - 32'd1;
    last_block = (bi_inc == bt);

    phase_next        = ph;
    blocks_total_next = bt;
    block_index_next  = bi;
    next_address_next = na;
    words_left_next   = wl;
    we   = 1'b0;
    addr = '0;
    data = '0;
    st   = ST_IGNORED;

    case (ph)
      PH_ID: begin
        if (q_item.id_match) begin
          phase_next = PH_COUNT;
          st         = ST_HEADER;
        end else begin
          phase_next = PH_ERR_ID;
          st         = ST_BAD_ID;
        end
      end
      PH_COUNT: begin
        blocks_total_next = q_item.word;
        block_index_next  = '0;
        if (q_item.word == '0) begin
          phase_next = PH_DONE;
          st         = ST_DONE;
        end else begin
          phase_next = PH_SEP1;
          st         = ST_HEADER;
        end
      end
      PH_SEP1, PH_SEP2: begin
        if (q_item.sep_match) begin
          phase_next = (ph == PH_SEP1) ? PH_SEP2 : PH_NUMBER;
          st         = ST_HEADER;
        end else begin
          phase_next = PH_ERR_SEP;
          st         = ST_BAD_SEP;
        end
      end
      PH_NUMBER: begin
        if (q_item.word == bi) begin
          phase_next = PH_BLKID;
          st         = ST_HEADER;
        end else begin
          phase_next = PH_ERR_SEQ;
          st         = ST_BAD_SEQ;
        end
      end
      PH_BLKID: begin
        phase_next = PH_ADDR;
        st         = ST_HEADER;
      end
      PH_ADDR: begin
        next_address_next = q_item.word;
        phase_next        = PH_LENGTH;
        st                = ST_HEADER;
      end
      PH_LENGTH: begin
        words_left_next = q_item.word;
        phase_next      = PH_SEP3;
        st              = ST_HEADER;
      end
      PH_SEP3: begin
        if (!q_item.sep_match) begin
          phase_next = PH_ERR_SEP;
          st         = ST_BAD_SEP;
        end else if (wl == '0) begin
          // An empty block ends at its third separator.
          block_index_next = bi_inc;
          phase_next       = last_block ? PH_DONE : PH_SEP1;
          st               = last_block ? ST_DONE : ST_HEADER;
        end else begin
          phase_next = PH_DATA;
          st         = ST_HEADER;
        end
      end
      PH_DATA: begin
        we                = 1'b1;
        addr              = na;
        data              = q_item.word;
        next_address_next = na + 32'd1;
        words_left_next   = wl_dec;
        st                = ST_DATA;
        if (wl_dec == '0) begin
          block_index_next = bi_inc;
          phase_next       = last_block ? PH_DONE : PH_SEP1;
          st               = last_block ? ST_DONE : ST_DATA;
        end
      end
      PH_ERR_ID:  st = ST_BAD_ID;
      PH_ERR_SEP: st = ST_BAD_SEP;
      PH_ERR_SEQ: st = ST_BAD_SEQ;
      default:    st = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      write_enable  <= we;
      write_address <= addr;
      write_data    <= data;
      status        <= st;
    end
  end

  a_write_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> (status == ST_DATA || status == ST_DONE))
    else $error("write issued with a non-data status");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (write_address == '0 && write_data == '0))
    else $error("address or data nonzero without a write");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (pop && !q_item.restart &&
     (phase == PH_ERR_ID || phase == PH_ERR_SEP || phase == PH_ERR_SEQ))
    |=> (phase == $past(phase)))
    else $error("latched error left without restart");

endmodule

### hw/rtl/program_image_block_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program image block loader
// Parses a program image word stream into memory write requests.
// ----------------------------------------------------------------------------
// The loader takes one image word per clock cycle and keeps that rate for as
// long as results are taken: a word is byte-ordered and compared against the
// identifier and separator values in the cycle it is accepted, waits in a
// two-entry queue, and the parser, which does one counter step per word,
// turns it into a result held in the output register until it is taken.
// Each request on the input channel gives exactly one result. The queue lets
// input requests keep arriving while a result waits for the output side.
// Registers must be written only while no words are in flight.
// ----------------------------------------------------------------------------
module program_image_block_loader
  import pibl_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          data_word,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 write_enable,
  output logic [31:0]          write_address,
  output logic [31:0]          write_data,
  output logic [2:0]           status
);

  logic [31:0] image_identifier;
  logic [31:0] separator_value;
  logic        swap_bytes;
  reg_index_t  reg_sel;
  logic        cfg_write;

  logic        queue_ready;
  logic        push;
  item_t       push_item;
  logic        pop;
  logic        q_valid;
  item_t       q_item;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_identifier <= '0;
      separator_value  <= '0;
      swap_bytes       <= 1'b0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_IMAGE_ID:  image_identifier <= pwdata;
        REG_SEPARATOR: separator_value  <= pwdata;
        REG_SWAP:      swap_bytes       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_ID:  prdata = image_identifier;
      REG_SEPARATOR: prdata = separator_value;
      REG_SWAP:      prdata = {31'd0, swap_bytes};
      default:       prdata = '0;
    endcase
  end

  pibl_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_word        (data_word),
    .restart          (restart),
    .image_identifier (image_identifier),
    .separator_value  (separator_value),
    .swap_bytes       (swap_bytes),
    .queue_ready      (queue_ready),
    .push             (push),
    .push_item        (push_item)
  );

  pibl_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (queue_ready),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  pibl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_enable  (write_enable),
    .write_address (write_address),
    .write_data    (write_data),
    .status        (status)
  );

endmodule
